// ===== hw/rtl/c3f_pkg.sv =====
package c3f_pkg;

  localparam int PIX_W         = 8;
  localparam int FRAME_W       = 11;
  localparam int ROW_W         = 11;
  localparam int SHIFT_W       = 4;
  localparam int MAX_HEIGHT    = 1024;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_COEF_BITS = 10;
  localparam int CFG_IDX_W     = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // output queue; depth must be a power of two
  localparam int OFIFO_DEPTH = 8;
  localparam int FIFO_PTR_W  = $clog2(OFIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(OFIFO_DEPTH + 1);
  localparam int MAC_BUSY_W  = 3;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_TOP  = 3'd0,
    REG_K_MID  = 3'd1,
    REG_K_BOT  = 3'd2,
    REG_FRAC   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_reg_t;

  // which window columns feed the left/center/right taps
  typedef enum logic [1:0] {
    COL_INNER      = 2'd0,
    COL_LEFT_EDGE  = 2'd1,
    COL_RIGHT_EDGE = 2'd2
  } col_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

  typedef struct packed {
    logic      valid;
    logic      last;
    col_mode_t mode;
    logic      top_edge;
    logic      bot_edge;
  } win_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_t;

endpackage

// ===== hw/rtl/c3f_col_cell.sv =====
module c3f_col_cell
  import c3f_pkg::*;
(
  input  logic     clk,
  input  logic     shift,
  input  win_col_t d,
  output win_col_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/c3f_mac.sv =====
module c3f_mac
  import c3f_pkg::*;
#(
  parameter int COEF_BITS = DEF_COEF_BITS,
  localparam int KW = 3 * COEF_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [KW-1:0]         k_top,
  input  logic [KW-1:0]         k_mid,
  input  logic [KW-1:0]         k_bot,
  input  logic [SHIFT_W-1:0]    fraction_shift,
  input  win_col_t              win [3],
  input  win_ctl_t              ctl_in,
  output logic                  res_valid,
  output res_t                  res,
  output logic [MAC_BUSY_W-1:0] busy
);

  localparam int PRW = COEF_BITS + PIX_W + 1;
  localparam int RSW = PRW + 2;
  localparam int TW  = PRW + 4;

  win_ctl_t                c_ctl;
  logic [KW-1:0]           krow [3];
  win_col_t                col_sel [3];
  logic [PIX_W-1:0]        px [3][3];
  logic signed [PRW-1:0]   prod_next [3][3];
  logic signed [PRW-1:0]   prod [3][3];
  logic                    s1_valid, s1_last;
  logic signed [RSW-1:0]   rsum [3];
  logic                    s2_valid, s2_last;
  logic signed [TW-1:0]    total;
  logic                    s3_valid, s3_last;
  logic [TW-1:0]           shifted;
  res_t                    res_next;

  always_comb begin
    krow[0] = k_top;
    krow[1] = k_mid;
    krow[2] = k_bot;
    col_sel[0] = (c_ctl.mode == COL_LEFT_EDGE) ? win[1] : win[0];
    col_sel[1] = win[1];
    col_sel[2] = (c_ctl.mode == COL_RIGHT_EDGE) ? win[1] : win[2];
    for (int k = 0; k < 3; k++) begin
      px[0][k] = c_ctl.top_edge ? col_sel[k].mid : col_sel[k].top;
      px[1][k] = col_sel[k].mid;
      px[2][k] = c_ctl.bot_edge ? col_sel[k].mid : col_sel[k].bot;
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_next[r][k] = $signed({1'b0, px[r][k]})
                        * $signed(krow[r][k*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  always_comb begin
    shifted = $unsigned(total) >> fraction_shift;
    res_next.last = s3_last;
    if (total <= 0) begin
      res_next.pixel = '0;
    end else if (shifted > TW'(PIX_MAX)) begin
      res_next.pixel = PIX_MAX;
    end else begin
      res_next.pixel = shifted[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl     <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      c_ctl     <= ctl_in;
      s1_valid  <= c_ctl.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= prod_next;
    s1_last <= c_ctl.last;
    for (int r = 0; r < 3; r++) begin
      rsum[r] <= RSW'(prod[r][0]) + RSW'(prod[r][1]) + RSW'(prod[r][2]);
    end
    s2_last <= s1_last;
    total   <= TW'(rsum[0]) + TW'(rsum[1]) + TW'(rsum[2]);
    s3_last <= s2_last;
    res     <= res_next;
  end

  assign busy = MAC_BUSY_W'($countones({c_ctl.valid, s1_valid, s2_valid, s3_valid,
                                         res_valid}));

endmodule

// ===== hw/rtl/c3f_fifo.sv =====
module c3f_fifo
  import c3f_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  res_t                  din,
  input  logic                  pop,
  output logic                  not_empty,
  output res_t                  dout,
  output logic [FIFO_CNT_W-1:0] count
);

  res_t                  mem [OFIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  assign dout      = mem[rp];
  assign not_empty = (count != '0);

endmodule

// ===== hw/rtl/conv3x3_clamped_filter_top.sv =====
// Path: input register, window cells, products, row sums, total, result, queue.
// Throughput: one word per cycle while item_ready is high; results trail the input by
// one line plus one pixel. The line memory (one read and one write port, registered
// read) sets the rate. Reset: synchronous, clears positions, pipeline and output queue
// and restores the register defaults; the line memory is not cleared.
module conv3x3_clamped_filter_top
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS,
  localparam int KW         = 3 * COEF_BITS,
  localparam int PW         = (KW > 32) ? 64 : 32,
  localparam int STRIDE_LOG = (KW > 32) ? 3 : 2,
  localparam int AW         = STRIDE_LOG + CFG_IDX_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic             opcode,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [PIX_W-1:0] pixel_out,
  output logic             last_of_frame,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AW-1:0]    paddr,
  input  logic [PW-1:0]    pwdata,
  output logic [PW-1:0]    prdata,
  output logic             pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = (COL_W + 1 > FRAME_W) ? COL_W + 1 : FRAME_W;
  localparam int OCC_W = FIFO_CNT_W + 1;

  localparam logic [KW-1:0] K_EDGE_RST = KW'(1) << COEF_BITS;
  localparam logic [KW-1:0] K_MID_RST  = KW'(1)
                                       | (KW'((1 << COEF_BITS) - 4) << COEF_BITS)
                                       | (KW'(1) << (2 * COEF_BITS));

  // configuration registers
  logic [KW-1:0]      kernel_top_row, kernel_middle_row, kernel_bottom_row;
  logic [SHIFT_W-1:0] fraction_shift;
  logic [FRAME_W-1:0] frame_width, frame_height;
  cfg_reg_t           reg_idx;
  logic               cfg_wr;

  // positions
  logic [COL_W-1:0] in_column, out_column;
  logic [ROW_W-1:0] in_row, out_row;

  logic [EW_W-1:0]  fw_ext, eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             take, eff, draining, emit, last, col_wrap, out_wrap;
  logic [PIX_W-1:0] p;
  win_ctl_t         ctl_next;

  // line memory: {older line, newer line} per column
  logic [2*PIX_W-1:0] lmem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd;

  logic             b_valid;
  logic [PIX_W-1:0] b_pix;
  logic [COL_W-1:0] b_addr;
  win_ctl_t         b_ctl;
  win_ctl_t         mac_ctl;

  win_col_t win [3];
  win_col_t win_d [3];

  logic                  mac_valid;
  res_t                  mac_res;
  logic [MAC_BUSY_W-1:0] mac_busy;
  res_t                  q_res;
  logic [FIFO_CNT_W-1:0] q_count;
  logic                  q_pop;
  logic [OCC_W-1:0]      occ;

  // APB
  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_t'(paddr[AW-1:STRIDE_LOG]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_top_row    <= K_EDGE_RST;
      kernel_middle_row <= K_MID_RST;
      kernel_bottom_row <= K_EDGE_RST;
      fraction_shift    <= '0;
      frame_width       <= FRAME_W'(MAX_HEIGHT);
      frame_height      <= FRAME_W'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_K_TOP:  kernel_top_row    <= pwdata[KW-1:0];
        REG_K_MID:  kernel_middle_row <= pwdata[KW-1:0];
        REG_K_BOT:  kernel_bottom_row <= pwdata[KW-1:0];
        REG_FRAC:   fraction_shift    <= pwdata[SHIFT_W-1:0];
        REG_WIDTH:  frame_width       <= pwdata[FRAME_W-1:0];
        REG_HEIGHT: frame_height      <= pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_K_TOP:  prdata = PW'(kernel_top_row);
      REG_K_MID:  prdata = PW'(kernel_middle_row);
      REG_K_BOT:  prdata = PW'(kernel_bottom_row);
      REG_FRAC:   prdata = PW'(fraction_shift);
      REG_WIDTH:  prdata = PW'(frame_width);
      REG_HEIGHT: prdata = PW'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // frame size, saturated
  always_comb begin
    fw_ext = EW_W'(frame_width);
    if (fw_ext < EW_W'(2)) begin
      eff_w = EW_W'(2);
    end else if (fw_ext > EW_W'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    if (frame_height < FRAME_W'(2)) begin
      eff_h = ROW_W'(2);
    end else if (frame_height > FRAME_W'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(frame_height);
    end
  end

  // input stage
  always_comb begin
    take     = item_valid && item_ready;
    draining = in_row >= eff_h;
    eff      = take && (draining || opcode == OP_PIXEL);
    p        = draining ? '0 : pixel_in;
    emit     = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_column != '0);
    last     = in_row >= eff_h + ROW_W'(1);
    col_wrap = (EW_W'(in_column) + EW_W'(1)) >= eff_w;
    out_wrap = (EW_W'(out_column) + EW_W'(1)) >= eff_w;

    ctl_next.valid    = emit;
    ctl_next.last     = last;
    ctl_next.top_edge = (out_row == '0);
    ctl_next.bot_edge = (out_row + ROW_W'(1)) >= eff_h;
    if (in_column == '0) begin
      ctl_next.mode = COL_RIGHT_EDGE;
    end else if (in_column == COL_W'(1)) begin
      ctl_next.mode = COL_LEFT_EDGE;
    end else begin
      ctl_next.mode = COL_INNER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      b_valid    <= 1'b0;
    end else begin
      b_valid <= eff;
      if (eff) begin
        if (last) begin
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end else begin
          if (col_wrap) begin
            in_column <= '0;
            in_row    <= in_row + ROW_W'(1);
          end else begin
            in_column <= in_column + COL_W'(1);
          end
          if (emit) begin
            if (out_wrap) begin
              out_column <= '0;
              out_row    <= out_row + ROW_W'(1);
            end else begin
              out_column <= out_column + COL_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eff) begin
      b_pix  <= p;
      b_addr <= in_column;
      b_ctl  <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    rd <= lmem[in_column];
    if (b_valid) begin
      lmem[b_addr] <= {rd[PIX_W-1:0], b_pix};
    end
  end

  // window: chain of column cells, newest at index 2
  always_comb begin
    win_d[2].top = rd[2*PIX_W-1:PIX_W];
    win_d[2].mid = rd[PIX_W-1:0];
    win_d[2].bot = b_pix;
    win_d[1]     = win[2];
    win_d[0]     = win[1];
    mac_ctl       = b_ctl;
    mac_ctl.valid = b_valid && b_ctl.valid;
  end

  for (genvar i = 0; i < 3; i++) begin : g_cell
    c3f_col_cell u_cell (
      .clk   (clk),
      .shift (b_valid),
      .d     (win_d[i]),
      .q     (win[i])
    );
  end

  c3f_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk            (clk),
    .rst            (rst),
    .k_top          (kernel_top_row),
    .k_mid          (kernel_middle_row),
    .k_bot          (kernel_bottom_row),
    .fraction_shift (fraction_shift),
    .win            (win),
    .ctl_in         (mac_ctl),
    .res_valid      (mac_valid),
    .res            (mac_res),
    .busy           (mac_busy)
  );

  assign q_pop = result_valid && result_ready;

  c3f_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mac_valid),
    .din       (mac_res),
    .pop       (q_pop),
    .not_empty (result_valid),
    .dout      (q_res),
    .count     (q_count)
  );

  assign pixel_out     = q_res.pixel;
  assign last_of_frame = q_res.last;

  // words in flight toward the queue plus words queued
  assign occ        = OCC_W'(mac_ctl.valid) + OCC_W'(mac_busy) + OCC_W'(q_count);
  assign item_ready = occ < OCC_W'(OFIFO_DEPTH);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(OFIFO_DEPTH))
    else $error("output queue credit exceeded");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    mac_valid |-> (q_count != FIFO_CNT_W'(OFIFO_DEPTH)) || q_pop)
    else $error("result pushed into full queue");

  a_addr_split: assert property (@(posedge clk) disable iff (rst)
    b_valid && eff && !b_ctl.last |-> b_addr != in_column)
    else $error("line memory read and write hit the same column");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    eff && last |=> in_row == '0 && in_column == '0 && out_row == '0 && out_column == '0)
    else $error("positions not cleared after final drain word");
`endif

endmodule

// ===== bench/tb_conv3x3_clamped_filter_top.sv =====
module tb_conv3x3_clamped_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import c3f_pkg::*;

  localparam int CB    = DEF_COEF_BITS;
  localparam int KBITS = 3 * DEF_COEF_BITS;
  localparam int AW    = 2 + CFG_IDX_W;

  // filter predictor and store of expected output words
  class conv_scoreboard;
    bit [7:0]       line_a[DEF_MAX_WIDTH];
    bit [7:0]       line_b[DEF_MAX_WIDTH];
    bit [7:0]       win[3][3];  // [column][row], column 2 newest, row 2 lowest
    int             in_col, in_row, out_col, out_row;
    bit [KBITS-1:0] kern[3] = '{30'd1024, 30'd2093057, 30'd1024};
    bit [3:0]       frac;
    bit [10:0]      fw = 11'd1024;
    bit [10:0]      fh = 11'd1024;
    res_t           expected_px[$];
    int             errors;

    task report_mismatch(string msg);
      if (errors < 40) $display("ERROR %0t ns: %s", $time, msg);
      errors++;
    endtask

    function int clip(bit [10:0] v, int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return int'(v);
    endfunction

    function int eff_width();
      return clip(fw, DEF_MAX_WIDTH);
    endfunction

    function int eff_height();
      return clip(fh, MAX_HEIGHT);
    endfunction

    function bit [31:0] set_reg(cfg_reg_t idx, bit [31:0] v);
      case (idx)
        REG_K_TOP: begin
          kern[0] = v[KBITS-1:0];
          return 32'(kern[0]);
        end
        REG_K_MID: begin
          kern[1] = v[KBITS-1:0];
          return 32'(kern[1]);
        end
        REG_K_BOT: begin
          kern[2] = v[KBITS-1:0];
          return 32'(kern[2]);
        end
        REG_FRAC: begin
          frac = v[3:0];
          return 32'(frac);
        end
        REG_WIDTH: begin
          fw = v[10:0];
          return 32'(fw);
        end
        REG_HEIGHT: begin
          fh = v[10:0];
          return 32'(fh);
        end
        default: return 32'd0;
      endcase
    endfunction

    function bit [7:0] weigh(int lc, int cc, int rc, int h);
      int cols[3];
      int rows[3];
      int sum;
      logic signed [CB-1:0] cf;
      cols = '{lc, cc, rc};
      rows[0] = (out_row == 0) ? 1 : 0;
      rows[1] = 1;
      rows[2] = (out_row + 1 >= h) ? 1 : 2;
      sum = 0;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) begin
          cf = kern[r][k*CB +: CB];
          sum += int'(cf) * int'(win[cols[k]][rows[r]]);
        end
      if (sum <= 0) return 8'd0;
      sum = sum >> frac;
      return (sum > 255) ? PIX_MAX : sum[7:0];
    endfunction

    task note_word(op_t op, bit [7:0] pix);
      int w, h, c;
      bit draining, emit, fin;
      bit [7:0] val, top, mid;
      res_t r;
      w = eff_width();
      h = eff_height();
      draining = (in_row >= h);
      if (!draining && op == OP_FLUSH) return;
      if (draining) pix = 8'd0;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      fin = (in_row >= h + 1);
      val = 8'd0;
      if (in_col == 0 && emit) val = weigh(1, 2, 2, h);
      c = (in_col < DEF_MAX_WIDTH) ? in_col : 0;
      top = line_a[c];
      mid = line_b[c];
      line_a[c] = mid;
      line_b[c] = pix;
      for (int rr = 0; rr < 3; rr++) begin
        win[0][rr] = win[1][rr];
        win[1][rr] = win[2][rr];
      end
      win[2][0] = top;
      win[2][1] = mid;
      win[2][2] = pix;
      if (in_col != 0 && emit) val = weigh((in_col == 1) ? 1 : 0, 1, 2, h);
      if (fin) begin
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
      end else begin
        if (in_col + 1 >= w) begin
          in_col = 0;
          in_row++;
        end else in_col++;
        if (emit) begin
          if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
          end else out_col++;
        end
      end
      if (emit) begin
        r.pixel = val;
        r.last = fin;
        expected_px.push_back(r);
      end
    endtask

    task check_word(logic [7:0] px, logic lst);
      res_t e;
      if (expected_px.size() == 0) begin
        report_mismatch($sformatf("unexpected word pixel_out %0d", px));
        return;
      end
      e = expected_px.pop_front();
      if (px !== e.pixel)
        report_mismatch($sformatf("pixel_out %0d, expected %0d", px, e.pixel));
      if (lst !== e.last)
        report_mismatch($sformatf("last_of_frame %b, expected %b", lst, e.last));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  logic             opcode = OP_PIXEL;
  logic [PIX_W-1:0] pixel_in = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AW-1:0]    paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  conv_scoreboard sb = new;
  int unsigned    idle_pct = 14;
  bit             hold_req;
  int             stall_left;
  int             counted;

  conv3x3_clamped_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .last_of_frame(last_of_frame),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("conv3x3_clamped_filter_top: mismatch");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && result_ready)
        sb.check_word(pixel_out, last_of_frame);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic apb_write(cfg_reg_t idx, bit [31:0] v);
    bit [31:0] want;
    want = sb.set_reg(idx, v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                   idx.name(), prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(bit [31:0] kt, bit [31:0] km, bit [31:0] kb,
                            bit [31:0] shift, bit [31:0] w, bit [31:0] h);
    apb_write(REG_K_TOP, kt);
    apb_write(REG_K_MID, km);
    apb_write(REG_K_BOT, kb);
    apb_write(REG_FRAC, shift);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
  endtask

  task automatic send_word(op_t op, bit [7:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    pixel_in <= pix;
    do @(posedge clk); while (!item_ready);
    sb.note_word(op, pix);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic bit [31:0] krow(int l, int c, int r);
    bit [CB-1:0] a, b, d;
    a = CB'(l);
    b = CB'(c);
    d = CB'(r);
    return {2'b00, d, b, a};
  endfunction

  function automatic bit [31:0] rand_row(bit wide);
    bit [CB-1:0] c[3];
    for (int k = 0; k < 3; k++)
      c[k] = wide ? CB'($urandom_range(1023)) : CB'($urandom_range(16) - 8);
    return {2'b00, c[2], c[1], c[0]};
  endfunction

  function automatic bit [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_frame(int hold_at, int pause_at);
    int w, h;
    op_t dop;
    w = sb.eff_width();
    h = sb.eff_height();
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 5) send_word(OP_FLUSH, 8'($urandom_range(255)));
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) begin
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_px.size() != 0) @(posedge clk);
      end
      send_word(OP_PIXEL, pick_pixel());
    end
    // drain: one line plus one word, mixing flush ticks and dropped samples
    for (int i = 0; i <= w; i++) begin
      dop = ($urandom_range(3) == 0) ? OP_PIXEL : OP_FLUSH;
      send_word(dop, 8'($urandom_range(255)));
    end
    counted += w * h + w + 1;
    settle();
  endtask

  initial begin
    int  frame_no;
    int  fw, fh;
    bit  wide;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme coefficients, sizes below range, early flush, sample while draining
    set_filter(krow(-512, -512, -512), krow(511, 511, 511), krow(1, -1, 0), 0, 1, 0);
    send_word(OP_FLUSH, 8'hFF);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd0);
    send_word(OP_PIXEL, 8'd0);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_FLUSH, 8'd0);
    send_word(OP_FLUSH, 8'd255);
    settle();

    // largest fraction shift
    set_filter(krow(511, 511, 511), krow(511, 511, 511), krow(511, 511, 511), 15, 3, 2);
    repeat (6) send_word(OP_PIXEL, 8'd255);
    send_word(OP_FLUSH, 8'd0);
    send_word(OP_FLUSH, 8'd0);
    send_word(OP_FLUSH, 8'd0);
    send_word(OP_PIXEL, 8'd0);
    settle();

    // Laplacian
    set_filter(krow(0, 1, 0), krow(1, -4, 1), krow(0, 1, 0), 0, 2, 2);
    send_word(OP_PIXEL, 8'd0);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd1);
    repeat (3) send_word(OP_FLUSH, 8'd0);
    settle();

    counted = 0;
    frame_no = 0;
    while (counted < 450) begin
      wide = ($urandom_range(3) == 0);
      if (frame_no == 0 || frame_no == 2) begin
        fw = 20;
        fh = (frame_no == 0) ? 8 : 6;
      end else begin
        fw = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
        fh = $urandom_range(2, 6);
      end
      set_filter(rand_row(wide), rand_row(wide), rand_row(wide),
                 wide ? $urandom_range(6, 15) : $urandom_range(0, 4), fw, fh);
      idle_pct = (frame_no == 2) ? 0 : 14;
      run_frame((frame_no == 0) ? 40 : -1, (frame_no == 3) ? fw * fh / 2 : -1);
      frame_no++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("conv3x3_clamped_filter_top: match");
    end else begin
      $display("conv3x3_clamped_filter_top: mismatch");
    end
    $finish;
  end

endmodule
